### rtl/lcf_pkg.sv
// Shared types, constants and helper functions for the LCD command byte formatter.
package lcf_pkg;

  localparam int DIM_W   = 10;  // width of the screen size registers
  localparam int COORD_W = 16;  // width of a coordinate on the input
  localparam int CFG_W   = 10;  // widest configuration register
  localparam int CFG_AW  = 2;   // configuration register index width
  localparam int QDEPTH  = 4;   // entries in the front-to-back queue
  localparam int QAW     = $clog2(QDEPTH);
  localparam int STEP_W  = 4;   // byte counter, up to thirteen bytes per job

  localparam logic [DIM_W-1:0] RESET_WIDTH  = DIM_W'(240);
  localparam logic [DIM_W-1:0] RESET_HEIGHT = DIM_W'(320);
  localparam logic [1:0]       RESET_ROT    = 2'd0;

  localparam logic [CFG_AW-1:0] CFG_PANEL_WIDTH    = CFG_AW'(0);
  localparam logic [CFG_AW-1:0] CFG_PANEL_HEIGHT   = CFG_AW'(1);
  localparam logic [CFG_AW-1:0] CFG_START_ROTATION = CFG_AW'(2);

  localparam logic [7:0] CMD_CASET  = 8'h2A;
  localparam logic [7:0] CMD_RASET  = 8'h2B;
  localparam logic [7:0] CMD_RAMWR  = 8'h2C;
  localparam logic [7:0] CMD_MADCTL = 8'h36;

  // Byte counter values that mark the steps and the ends of the request kinds.
  localparam logic [STEP_W-1:0] STEP_WIN_END   = STEP_W'(10);
  localparam logic [STEP_W-1:0] STEP_PIX_COLHI = STEP_W'(11);
  localparam logic [STEP_W-1:0] STEP_PIX_END   = STEP_W'(12);
  localparam logic [STEP_W-1:0] STEP_ROT_MAD   = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_ROT_WIN   = STEP_W'(2);
  localparam logic [STEP_W-1:0] STEP_ROT_END   = STEP_W'(11);

  typedef enum logic [1:0] {
    OP_WINDOW = 2'd0,
    OP_PIXEL  = 2'd1,
    OP_ROTATE = 2'd2,
    OP_DATA   = 2'd3
  } op_e_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [COORD_W-1:0] x_start;
    logic [COORD_W-1:0] y_start;
    logic [COORD_W-1:0] x_end;
    logic [COORD_W-1:0] y_end;
    logic [15:0]        color;
    logic [1:0]         new_rotation;
    logic [7:0]         data_byte;
    logic               buffer_end;
  } in_word_t;

  typedef struct packed {
    logic [7:0] bus_byte;
    logic       is_command;
    logic       last;
  } out_word_t;

  // One classified request, ready for the byte sequencer.
  typedef struct packed {
    op_e_t              kind;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] y1;
    logic [15:0]        color;
    logic [7:0]         aux;   // MADCTL value or raw data byte
    logic               flag;  // size changed, or buffer end
  } job_t;

  function automatic logic [7:0] madctl_value(input logic [1:0] rot);
    logic [7:0] v;
    case (rot)
      2'd0:    v = 8'h00;
      2'd1:    v = 8'h60;
      2'd2:    v = 8'hC0;
      default: v = 8'hA0;
    endcase
    return v;
  endfunction

  function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v,
                                                     input logic [DIM_W-1:0]   size);
    logic [COORD_W-1:0] r;
    if (v >= COORD_W'(size)) begin
      r = (size == '0) ? '0 : COORD_W'(size) - COORD_W'(1);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

### rtl/lcd_command_byte_formatter.sv
// Top level of the LCD command byte formatter: front end, job queue, byte sequencer.
// The first byte of a request passes the queue write at the accepting edge, then the job
// load, then the output register, before it shows on the output.
// One output byte per cycle while out_ready does not stall the byte-wide output register;
// a request has 1 byte for data, 2 or 12 for rotation, 11 for window, 13 for pixel.
// Reset (synchronous, rst_n low): queue and sequencer empty, size 240 x 320, rotation 0.
module lcd_command_byte_formatter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [lcf_pkg::CFG_AW-1:0]  cfg_index,
  input  logic [lcf_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  lcf_pkg::in_word_t           in_word,
  output logic                        out_valid,
  input  logic                        out_ready,
  output lcf_pkg::out_word_t          out_word
);
  import lcf_pkg::*;

  logic q_push, q_push_ready, q_pop, q_valid;
  job_t push_job, head_job;

  // Classify each request, clamp or screen its coordinates and track screen geometry.
  // Off-screen pixels are dropped here and never reach the queue.
  lcf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .q_ready   (q_push_ready),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  // Hold classified jobs so the input side keeps taking words while bytes drain.
  lcf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (push_job),
    .push_ready (q_push_ready),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (head_job)
  );

  // Step through each job one byte per cycle while the output is not stalled; load the next
  // job on the last byte so requests follow each other with no bubble.
  lcf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_job     (head_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

### rtl/lcf_front.sv
// Front end: accepts requests, keeps screen size and rotation, builds jobs.
module lcf_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [lcf_pkg::CFG_AW-1:0]       cfg_index,
  input  logic [lcf_pkg::CFG_W-1:0]        cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  lcf_pkg::in_word_t                in_word,
  input  logic                             q_ready,
  output logic                             q_push,
  output lcf_pkg::job_t                    q_job
);
  import lcf_pkg::*;

  logic [DIM_W-1:0] cur_width_r,  cur_width_nxt;
  logic [DIM_W-1:0] cur_height_r, cur_height_nxt;
  logic [1:0]       cur_rot_r,    cur_rot_nxt;
  logic             in_fire;
  logic             drop;
  logic             swap;
  op_e_t            op;

  assign in_ready = q_ready;
  assign in_fire  = in_valid && in_ready;
  assign op       = op_e_t'(in_word.operation);
  assign swap     = cur_rot_r[0] ^ in_word.new_rotation[0];

  always_comb begin
    q_job          = '0;
    q_job.kind     = op;
    drop           = 1'b0;
    cur_width_nxt  = cur_width_r;
    cur_height_nxt = cur_height_r;
    cur_rot_nxt    = cur_rot_r;
    unique case (op)
      OP_WINDOW: begin
        q_job.x0 = clamp_coord(in_word.x_start, cur_width_r);
        q_job.x1 = clamp_coord(in_word.x_end,   cur_width_r);
        q_job.y0 = clamp_coord(in_word.y_start, cur_height_r);
        q_job.y1 = clamp_coord(in_word.y_end,   cur_height_r);
      end
      OP_PIXEL: begin
        q_job.x0    = in_word.x_start;
        q_job.x1    = in_word.x_start;
        q_job.y0    = in_word.y_start;
        q_job.y1    = in_word.y_start;
        q_job.color = in_word.color;
        drop = (in_word.x_start >= COORD_W'(cur_width_r)) ||
               (in_word.y_start >= COORD_W'(cur_height_r));
      end
      OP_ROTATE: begin
        // odd quarter-turn difference swaps the axes
        cur_width_nxt  = swap ? cur_height_r : cur_width_r;
        cur_height_nxt = swap ? cur_width_r  : cur_height_r;
        cur_rot_nxt    = in_word.new_rotation;
        q_job.x1       = COORD_W'(cur_width_nxt);
        q_job.y1       = COORD_W'(cur_height_nxt);
        q_job.aux      = madctl_value(in_word.new_rotation);
        q_job.flag     = swap && (cur_width_r != cur_height_r);
      end
      OP_DATA: begin
        q_job.aux  = in_word.data_byte;
        q_job.flag = in_word.buffer_end;
      end
      default: ;
    endcase
  end

  assign q_push = in_fire && !drop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_width_r  <= RESET_WIDTH;
      cur_height_r <= RESET_HEIGHT;
      cur_rot_r    <= RESET_ROT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PANEL_WIDTH:    cur_width_r  <= DIM_W'(cfg_data);
        CFG_PANEL_HEIGHT:   cur_height_r <= DIM_W'(cfg_data);
        CFG_START_ROTATION: cur_rot_r    <= cfg_data[1:0];
        default: ;
      endcase
    end else if (in_fire) begin
      cur_width_r  <= cur_width_nxt;
      cur_height_r <= cur_height_nxt;
      cur_rot_r    <= cur_rot_nxt;
    end
  end

endmodule

### rtl/lcf_queue.sv
// Small register queue of jobs between the front end and the byte sequencer.
module lcf_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  lcf_pkg::job_t push_job,
  output logic          push_ready,
  input  logic          pop,
  output logic          head_valid,
  output lcf_pkg::job_t head_job
);
  import lcf_pkg::*;

  job_t             mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QAW:0]     count_r;
  logic             do_push, do_pop;

  assign push_ready = (count_r != (QAW+1)'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = mem_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + QAW'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + QAW'(1);
      if (do_push && !do_pop) begin
        count_r <= count_r + (QAW+1)'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - (QAW+1)'(1);
      end
    end
  end

endmodule

### rtl/lcf_back.sv
// Back end: walks a job byte by byte into the output register.
module lcf_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  lcf_pkg::job_t        q_job,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lcf_pkg::out_word_t   out_word
);
  import lcf_pkg::*;

  job_t              job_r;
  logic              job_valid_r;
  logic [STEP_W-1:0] step_r;
  logic              out_valid_r;
  out_word_t         out_word_r;
  out_word_t         gen;
  logic [STEP_W-1:0] widx;
  logic [7:0]        win_byte;
  logic              win_cmd;
  logic              adv;
  logic              job_end;

  // Window part: CASET, x0, x1, RASET, y0, y1, RAMWR.
  always_comb begin
    win_cmd  = 1'b0;
    win_byte = 8'h00;
    case (widx)
      STEP_W'(0):  begin win_byte = CMD_CASET; win_cmd = 1'b1; end
      STEP_W'(1):  win_byte = job_r.x0[15:8];
      STEP_W'(2):  win_byte = job_r.x0[7:0];
      STEP_W'(3):  win_byte = job_r.x1[15:8];
      STEP_W'(4):  win_byte = job_r.x1[7:0];
      STEP_W'(5):  begin win_byte = CMD_RASET; win_cmd = 1'b1; end
      STEP_W'(6):  win_byte = job_r.y0[15:8];
      STEP_W'(7):  win_byte = job_r.y0[7:0];
      STEP_W'(8):  win_byte = job_r.y1[15:8];
      STEP_W'(9):  win_byte = job_r.y1[7:0];
      default:     begin win_byte = CMD_RAMWR; win_cmd = 1'b1; end
    endcase
  end

  always_comb begin
    widx = step_r;
    gen  = '0;
    unique case (job_r.kind)
      OP_WINDOW: begin
        gen.bus_byte   = win_byte;
        gen.is_command = win_cmd;
        gen.last       = (step_r == STEP_WIN_END);
      end
      OP_PIXEL: begin
        if (step_r == STEP_PIX_COLHI) begin
          gen.bus_byte = job_r.color[15:8];
        end else if (step_r == STEP_PIX_END) begin
          gen.bus_byte = job_r.color[7:0];
          gen.last     = 1'b1;
        end else begin
          gen.bus_byte   = win_byte;
          gen.is_command = win_cmd;
        end
      end
      OP_ROTATE: begin
        widx = step_r - STEP_ROT_WIN;
        if (step_r == '0) begin
          gen.bus_byte   = CMD_MADCTL;
          gen.is_command = 1'b1;
        end else if (step_r == STEP_ROT_MAD) begin
          gen.bus_byte = job_r.aux;
          gen.last     = !job_r.flag;
        end else begin
          gen.bus_byte   = win_byte;
          gen.is_command = win_cmd;
          gen.last       = (step_r == STEP_ROT_END);
        end
      end
      OP_DATA: begin
        gen.bus_byte = job_r.aux;
        gen.last     = job_r.flag;
      end
      default: ;
    endcase
  end

  // A data job is always one byte, whatever its last flag says.
  assign job_end = gen.last || (job_r.kind == OP_DATA);

  assign adv   = job_valid_r && (!out_valid_r || out_ready);
  assign q_pop = q_valid && (!job_valid_r || (adv && job_end));

  always_ff @(posedge clk) begin
    if (q_pop) job_r <= q_job;
    if (adv)   out_word_r <= gen;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        job_valid_r <= 1'b1;
        step_r      <= '0;
      end else if (adv) begin
        job_valid_r <= !job_end;
        step_r      <= step_r + STEP_W'(1);
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

### rtl/lcf_checker.sv
// Port-level checker for the LCD command byte formatter, bound to the top level.
module lcf_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input lcf_pkg::out_word_t out_word
);
  import lcf_pkg::*;

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("output word changed while stalled");

  // A waiting input keeps in_valid high until its word is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid)
    else $error("input valid dropped before the word was taken");

  // Reset leaves no word on the output.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // Address and MADCTL commands always have bytes after them.
  a_cmd_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.is_command && (out_word.bus_byte != CMD_RAMWR)
    |-> !out_word.last)
    else $error("command other than memory write marked last");

endmodule

bind lcd_command_byte_formatter lcf_checker u_lcf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);
